FILE: src/lvc_pkg.sv
// Shared types and constants of the line viewport clipper.
// No dependencies; imported by every module of the block.
package lvc_pkg;

  localparam int FRAC_BITS = 8;
  localparam int INT_BITS  = 16;
  localparam int COORD_W   = INT_BITS + FRAC_BITS;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SUM_W     = 2 * COORD_W + 3;
  localparam int REM_W     = 2 * COORD_W + 4;
  localparam int DEN_W     = COORD_W + 2;
  localparam int ORD_W     = 2 * DIFF_W;
  localparam int NUM_EDGES = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam int HIT_W     = 3;

  localparam int EDGE_LEFT   = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_TOP    = 2;
  localparam int EDGE_BOTTOM = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MAX_X = 2'd2,
    REG_MAX_Y = 2'd3
  } cfg_reg_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
  } lvc_in_t;

  typedef struct packed {
    coord_t clip_x;
    coord_t clip_y;
    logic   point_valid;
    logic   last;
  } lvc_out_t;

  typedef struct packed {
    coord_t xmin;
    coord_t ymin;
    coord_t xmax;
    coord_t ymax;
  } lvc_view_t;

  typedef struct packed {
    logic [REM_W-1:0]   rem;
    logic [DEN_W-1:0]   den;
    logic [COORD_W-1:0] quo;
  } lvc_lane_t;

  typedef struct packed {
    lvc_in_t          pts;
    logic             in1;
    logic             in2;
    logic [HIT_W-1:0] hits;
    logic [1:0]       idx0;
    logic [1:0]       idx1;
    logic             swap;
  } lvc_ctl_t;

endpackage

FILE: src/lvc_front.sv
// Front end of the clipper: line equation, edge cuts, hit selection, ordering.
// Five elastic stages; uses lvc_pkg. Feeds the divider cell chain.
module lvc_front import lvc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lvc_view_t view_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lvc_in_t   in_data_i,
  output logic      valid_o,
  input  logic      ready_i,
  output lvc_ctl_t  ctl_o,
  output lvc_lane_t [NUM_EDGES-1:0] lane_o
);

  // stage A
  logic                     va_q;
  lvc_in_t                  pa_q;
  logic signed [SUM_W-1:0]  p1_q, p2_q;
  logic signed [DIFF_W-1:0] a_q, b_q;
  logic                     in1a_q, in2a_q;
  // stage B
  logic                     vb_q;
  lvc_in_t                  pb_q;
  logic                     in1b_q, in2b_q;
  logic signed [SUM_W-1:0]  c_q;
  logic signed [SUM_W-1:0]  fx_q [NUM_EDGES];
  logic signed [SUM_W-1:0]  lo_q [NUM_EDGES];
  logic signed [SUM_W-1:0]  hi_q [NUM_EDGES];
  logic                     neg_q [NUM_EDGES];
  logic [DIFF_W-1:0]        dvb_q [NUM_EDGES];
  logic [DIFF_W-1:0]        tnb_q [NUM_EDGES];
  // stage C
  logic                     vc_q;
  lvc_in_t                  pc_q;
  logic                     in1c_q, in2c_q;
  logic [NUM_EDGES-1:0]     hit_q;
  logic [DIFF_W-1:0]        tnc_q [NUM_EDGES];
  logic [DIFF_W-1:0]        tdc_q [NUM_EDGES];
  lvc_lane_t [NUM_EDGES-1:0] lanec_q;
  // stage D
  logic                     vd_q;
  lvc_ctl_t                 ctld_q;
  logic [ORD_W-1:0]         ord0_q, ord1_q;
  lvc_lane_t [NUM_EDGES-1:0] laned_q;
  // stage E
  logic                     ve_q;
  lvc_ctl_t                 ctle_q;
  lvc_lane_t [NUM_EDGES-1:0] lanee_q;

  logic en_a, en_b, en_c, en_d, en_e;

  assign en_e       = !ve_q || ready_i;
  assign en_d       = !vd_q || en_e;
  assign en_c       = !vc_q || en_d;
  assign en_b       = !vb_q || en_c;
  assign en_a       = !va_q || en_b;
  assign in_ready_o = en_a;

  // stage A: direction and cross products, inclusive inside tests
  logic in1_d, in2_d;
  assign in1_d = in_data_i.first_x >= view_i.xmin && in_data_i.first_x <= view_i.xmax &&
                 in_data_i.first_y >= view_i.ymin && in_data_i.first_y <= view_i.ymax;
  assign in2_d = in_data_i.second_x >= view_i.xmin && in_data_i.second_x <= view_i.xmax &&
                 in_data_i.second_y >= view_i.ymin && in_data_i.second_y <= view_i.ymax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) begin
      pa_q   <= in_data_i;
      p1_q   <= SUM_W'(in_data_i.first_x) * SUM_W'(in_data_i.second_y);
      p2_q   <= SUM_W'(in_data_i.second_x) * SUM_W'(in_data_i.first_y);
      a_q    <= DIFF_W'(in_data_i.first_y) - DIFF_W'(in_data_i.second_y);
      b_q    <= DIFF_W'(in_data_i.second_x) - DIFF_W'(in_data_i.first_x);
      in1a_q <= in1_d;
      in2a_q <= in2_d;
    end
  end

  // stage B: products against the edges
  logic [DIFF_W-1:0]        abs_a, abs_b;
  logic signed [DEN_W-1:0]  sabs_a, sabs_b;
  coord_t                   fix [NUM_EDGES];
  coord_t                   lo  [NUM_EDGES];
  coord_t                   hi  [NUM_EDGES];
  coord_t                   st  [NUM_EDGES];
  logic signed [DIFF_W-1:0] dd  [NUM_EDGES];

  assign abs_a  = a_q[DIFF_W-1] ? DIFF_W'(-a_q) : DIFF_W'(a_q);
  assign abs_b  = b_q[DIFF_W-1] ? DIFF_W'(-b_q) : DIFF_W'(b_q);
  assign sabs_a = signed'({1'b0, abs_a});
  assign sabs_b = signed'({1'b0, abs_b});

  always_comb begin
    fix[EDGE_LEFT]   = view_i.xmin;
    fix[EDGE_RIGHT]  = view_i.xmax;
    fix[EDGE_TOP]    = view_i.ymax;
    fix[EDGE_BOTTOM] = view_i.ymin;
    lo[EDGE_LEFT]    = view_i.ymin;
    lo[EDGE_RIGHT]   = view_i.ymin;
    lo[EDGE_TOP]     = view_i.xmin;
    lo[EDGE_BOTTOM]  = view_i.xmin;
    hi[EDGE_LEFT]    = view_i.ymax;
    hi[EDGE_RIGHT]   = view_i.ymax;
    hi[EDGE_TOP]     = view_i.xmax;
    hi[EDGE_BOTTOM]  = view_i.xmax;
    st[EDGE_LEFT]    = pa_q.first_x;
    st[EDGE_RIGHT]   = pa_q.first_x;
    st[EDGE_TOP]     = pa_q.first_y;
    st[EDGE_BOTTOM]  = pa_q.first_y;
    for (int e = 0; e < NUM_EDGES; e++) begin
      dd[e] = DIFF_W'(fix[e]) - DIFF_W'(st[e]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      pb_q   <= pa_q;
      in1b_q <= in1a_q;
      in2b_q <= in2a_q;
      c_q    <= p1_q - p2_q;
      for (int e = 0; e < NUM_EDGES; e++) begin
        if (e == EDGE_LEFT || e == EDGE_RIGHT) begin
          fx_q[e]  <= SUM_W'(a_q) * SUM_W'(fix[e]);
          lo_q[e]  <= SUM_W'(lo[e]) * SUM_W'(sabs_b);
          hi_q[e]  <= SUM_W'(hi[e]) * SUM_W'(sabs_b);
          neg_q[e] <= b_q[DIFF_W-1];
          dvb_q[e] <= abs_b;
        end else begin
          fx_q[e]  <= SUM_W'(b_q) * SUM_W'(fix[e]);
          lo_q[e]  <= SUM_W'(lo[e]) * SUM_W'(sabs_a);
          hi_q[e]  <= SUM_W'(hi[e]) * SUM_W'(sabs_a);
          neg_q[e] <= a_q[DIFF_W-1];
          dvb_q[e] <= abs_a;
        end
        tnb_q[e] <= dd[e][DIFF_W-1] ? DIFF_W'(-dd[e]) : DIFF_W'(dd[e]);
      end
    end
  end

  // stage C: strict interior test, divider operands
  logic signed [SUM_W-1:0] sm [NUM_EDGES];
  logic signed [SUM_W-1:0] nn [NUM_EDGES];
  logic [NUM_EDGES-1:0]    hit_d;
  lvc_lane_t [NUM_EDGES-1:0] lane_d;

  always_comb begin
    for (int e = 0; e < NUM_EDGES; e++) begin
      sm[e]         = fx_q[e] + c_q;
      nn[e]         = neg_q[e] ? sm[e] : -sm[e];
      hit_d[e]      = (dvb_q[e] != '0) && (nn[e] > lo_q[e]) && (nn[e] < hi_q[e]);
      // offset the quotient by half the coordinate range so it stays positive
      lane_d[e].rem = REM_W'((REM_W'(nn[e]) <<< 1) + REM_W'(dvb_q[e]) +
                             (REM_W'(dvb_q[e]) << COORD_W));
      lane_d[e].den = {1'b0, dvb_q[e]} << 1;
      lane_d[e].quo = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_c) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      pc_q    <= pb_q;
      in1c_q  <= in1b_q;
      in2c_q  <= in2b_q;
      hit_q   <= hit_d;
      lanec_q <= lane_d;
      for (int e = 0; e < NUM_EDGES; e++) begin
        tnc_q[e] <= tnb_q[e];
        tdc_q[e] <= dvb_q[e];
      end
    end
  end

  // stage D: pick the first two hits, cross-multiply their distances
  logic [HIT_W-1:0] cnt_d;
  logic [1:0]       idx0_d, idx1_d;

  always_comb begin
    cnt_d  = '0;
    idx0_d = '0;
    idx1_d = '0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (hit_q[e]) begin
        if (cnt_d == HIT_W'(0)) begin
          idx0_d = 2'(e);
        end else if (cnt_d == HIT_W'(1)) begin
          idx1_d = 2'(e);
        end
        cnt_d = cnt_d + HIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en_d) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      ctld_q.pts  <= pc_q;
      ctld_q.in1  <= in1c_q;
      ctld_q.in2  <= in2c_q;
      ctld_q.hits <= cnt_d;
      ctld_q.idx0 <= idx0_d;
      ctld_q.idx1 <= idx1_d;
      ctld_q.swap <= 1'b0;
      ord0_q      <= ORD_W'(tnc_q[idx0_d]) * ORD_W'(tdc_q[idx1_d]);
      ord1_q      <= ORD_W'(tnc_q[idx1_d]) * ORD_W'(tdc_q[idx0_d]);
      laned_q     <= lanec_q;
    end
  end

  // stage E: nearness order
  lvc_ctl_t ctle_d;

  always_comb begin
    ctle_d      = ctld_q;
    ctle_d.swap = (ctld_q.hits == HIT_W'(2)) && (ord0_q > ord1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (en_e) begin
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_e) begin
      ctle_q  <= ctle_d;
      lanee_q <= laned_q;
    end
  end

  assign valid_o = ve_q;
  assign ctl_o   = ctle_q;
  assign lane_o  = lanee_q;

endmodule

FILE: src/lvc_div_cell.sv
// One cell of the divider chain: one restoring quotient bit for each edge.
// Uses lvc_pkg; passes the control word along unchanged.
module lvc_div_cell import lvc_pkg::*; #(
  parameter int SHIFT = 0
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  output logic      ready_o,
  input  lvc_ctl_t  ctl_i,
  input  lvc_lane_t [NUM_EDGES-1:0] lane_i,
  output logic      valid_o,
  input  logic      ready_i,
  output lvc_ctl_t  ctl_o,
  output lvc_lane_t [NUM_EDGES-1:0] lane_o
);

  logic      v_q;
  lvc_ctl_t  ctl_q;
  lvc_lane_t [NUM_EDGES-1:0] lane_q, lane_d;
  logic      en;

  assign en      = !v_q || ready_i;
  assign ready_o = en;

  always_comb begin
    logic [REM_W-1:0] sub;
    logic             ge;
    for (int e = 0; e < NUM_EDGES; e++) begin
      sub           = REM_W'(lane_i[e].den) << SHIFT;
      ge            = lane_i[e].rem >= sub;
      lane_d[e].rem = ge ? lane_i[e].rem - sub : lane_i[e].rem;
      lane_d[e].den = lane_i[e].den;
      lane_d[e].quo = {lane_i[e].quo[COORD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q  <= ctl_i;
      lane_q <= lane_d;
    end
  end

  assign valid_o = v_q;
  assign ctl_o   = ctl_q;
  assign lane_o  = lane_q;

endmodule

FILE: src/lvc_out.sv
// Result assembly and output register of the clipper, one or two transfers per line.
// Uses lvc_pkg; fed by the last divider cell.
module lvc_out import lvc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lvc_view_t view_i,
  input  logic      valid_i,
  output logic      ready_o,
  input  lvc_ctl_t  ctl_i,
  input  lvc_lane_t [NUM_EDGES-1:0] lane_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output lvc_out_t  out_data_o
);

  coord_t   hx [NUM_EDGES];
  coord_t   hy [NUM_EDGES];
  coord_t   along [NUM_EDGES];
  lvc_out_t r0_d, r1_d, r0_q, r1_q, tmp;
  logic     two_d, two_q, v_q, ph_q, done;

  always_comb begin
    tmp = '0;
    for (int e = 0; e < NUM_EDGES; e++) begin
      along[e] = signed'({~lane_i[e].quo[COORD_W-1], lane_i[e].quo[COORD_W-2:0]});
    end
    hx[EDGE_LEFT]   = view_i.xmin;
    hy[EDGE_LEFT]   = along[EDGE_LEFT];
    hx[EDGE_RIGHT]  = view_i.xmax;
    hy[EDGE_RIGHT]  = along[EDGE_RIGHT];
    hx[EDGE_TOP]    = along[EDGE_TOP];
    hy[EDGE_TOP]    = view_i.ymax;
    hx[EDGE_BOTTOM] = along[EDGE_BOTTOM];
    hy[EDGE_BOTTOM] = view_i.ymin;

    r0_d.clip_x      = hx[ctl_i.idx0];
    r0_d.clip_y      = hy[ctl_i.idx0];
    r0_d.point_valid = 1'b1;
    r0_d.last        = 1'b0;
    r1_d.clip_x      = hx[ctl_i.idx1];
    r1_d.clip_y      = hy[ctl_i.idx1];
    r1_d.point_valid = 1'b1;
    r1_d.last        = 1'b1;
    two_d            = 1'b1;

    if (ctl_i.in1 && ctl_i.in2) begin
      r0_d.clip_x = ctl_i.pts.first_x;
      r0_d.clip_y = ctl_i.pts.first_y;
      r1_d.clip_x = ctl_i.pts.second_x;
      r1_d.clip_y = ctl_i.pts.second_y;
    end else if (ctl_i.hits == HIT_W'(0)) begin
      r0_d.clip_x      = '0;
      r0_d.clip_y      = '0;
      r0_d.point_valid = 1'b0;
      r0_d.last        = 1'b1;
      two_d            = 1'b0;
    end else if (ctl_i.hits == HIT_W'(1)) begin
      r0_d.last = 1'b1;
      two_d     = 1'b0;
    end else if (ctl_i.hits == HIT_W'(2)) begin
      if (ctl_i.swap) begin
        tmp       = r0_d;
        r0_d      = r1_d;
        r1_d      = tmp;
        r0_d.last = 1'b0;
        r1_d.last = 1'b1;
      end
      if (ctl_i.in1) begin
        r0_d.clip_x = ctl_i.pts.first_x;
        r0_d.clip_y = ctl_i.pts.first_y;
      end else if (ctl_i.in2) begin
        r1_d.clip_x = ctl_i.pts.second_x;
        r1_d.clip_y = ctl_i.pts.second_y;
      end
    end
  end

  assign done    = v_q && out_ready_i && (!two_q || ph_q);
  assign ready_o = !v_q || done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= 1'b0;
      ph_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      v_q  <= 1'b1;
      ph_q <= 1'b0;
    end else if (done) begin
      v_q  <= 1'b0;
      ph_q <= 1'b0;
    end else if (v_q && out_ready_i) begin
      ph_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      r0_q  <= r0_d;
      r1_q  <= r1_d;
      two_q <= two_d;
    end
  end

  assign out_valid_o = v_q;
  assign out_data_o  = ph_q ? r1_q : r0_q;

endmodule

FILE: src/line_viewport_clip_core.sv
// Top level of the line viewport clipper: config registers, front end,
// divider cell chain and output stage. Uses lvc_pkg, lvc_front, lvc_div_cell, lvc_out.
//
// Usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes two points of a line,
//   Q16.8 by default. out channel (out_valid_o/out_ready_i/out_data_o) gives
//   one or two clipped points per line; last marks the final transfer of a line.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i write the viewport edges (whole pixels);
//   write them only while no line is in flight.
//   Path from input transfer to first output transfer: 5 front-end stages,
//   one divider cell per quotient bit, then the output register.
//   Throughput, set by the output port at one result per cycle: one-result lines
//   go one per cycle while out_ready_i is high; two-result lines need two transfers.
//   Reset empties the pipeline and loads the viewport 0,0 .. 1023,767.
//   When the receiver stalls, results hold in the output register and the
//   stages behind it keep filling until full, then in_ready_o drops.
module line_viewport_clip_core import lvc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  lvc_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output lvc_out_t             out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  localparam int SAT_W = CFG_W + FRAC_BITS + 2;
  localparam logic signed [SAT_W-1:0] CMAX = SAT_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
  localparam logic signed [SAT_W-1:0] CMIN = -CMAX - SAT_W'(1);

  logic [CFG_W-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
  lvc_view_t        view;

  function automatic coord_t sat_edge(logic [CFG_W-1:0] r);
    logic signed [SAT_W-1:0] v;
    v = SAT_W'(signed'(r)) <<< FRAC_BITS;
    if (v > CMAX) begin
      return COORD_W'(CMAX);
    end else if (v < CMIN) begin
      return COORD_W'(CMIN);
    end
    return COORD_W'(v);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= CFG_W'(0);
      min_y_q <= CFG_W'(0);
      max_x_q <= CFG_W'(1023);
      max_y_q <= CFG_W'(767);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_X: min_x_q <= cfg_wdata_i;
        REG_MIN_Y: min_y_q <= cfg_wdata_i;
        REG_MAX_X: max_x_q <= cfg_wdata_i;
        REG_MAX_Y: max_y_q <= cfg_wdata_i;
      endcase
    end
  end

  assign view = '{xmin: sat_edge(min_x_q), ymin: sat_edge(min_y_q),
                  xmax: sat_edge(max_x_q), ymax: sat_edge(max_y_q)};

  logic      ch_valid [COORD_W+1];
  logic      ch_ready [COORD_W+1];
  lvc_ctl_t  ch_ctl   [COORD_W+1];
  lvc_lane_t [NUM_EDGES-1:0] ch_lane [COORD_W+1];

  lvc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .view_i     (view),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .valid_o    (ch_valid[0]),
    .ready_i    (ch_ready[0]),
    .ctl_o      (ch_ctl[0]),
    .lane_o     (ch_lane[0])
  );

  for (genvar k = 0; k < COORD_W; k++) begin : g_div
    lvc_div_cell #(
      .SHIFT (COORD_W - 1 - k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (ch_valid[k]),
      .ready_o (ch_ready[k]),
      .ctl_i   (ch_ctl[k]),
      .lane_i  (ch_lane[k]),
      .valid_o (ch_valid[k+1]),
      .ready_i (ch_ready[k+1]),
      .ctl_o   (ch_ctl[k+1]),
      .lane_o  (ch_lane[k+1])
    );
  end

  lvc_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .view_i      (view),
    .valid_i     (ch_valid[COORD_W]),
    .ready_o     (ch_ready[COORD_W]),
    .ctl_i       (ch_ctl[COORD_W]),
    .lane_i      (ch_lane[COORD_W]),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/sv/line_viewport_clip_core_tb.sv
// Self-checking testbench for line_viewport_clip_core: directed and random lines,
// several viewports, random input gaps and output stalls. Depends on lvc_pkg and the RTL.
module line_viewport_clip_core_tb;
  import lvc_pkg::*;

  localparam int LATENCY   = 40;
  localparam int WDOG_MAX  = 5000;
  localparam longint CMAX  = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint CMIN  = -CMAX - 1;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  lvc_in_t              in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  lvc_out_t             out_data_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_MIN_X;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;

  logic signed [15:0] vw_min_x = 16'sd0, vw_min_y = 16'sd0;
  logic signed [15:0] vw_max_x = 16'sd1023, vw_max_y = 16'sd767;

  lvc_out_t clip_expect_q[$];
  int       err_count = 0;
  int       idle_cycles = 0;
  bit       no_idle = 1'b0;
  int       stall_left = 0;

  line_viewport_clip_core u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  always #5 clk_i = ~clk_i;

  function automatic longint edge_fixed(logic signed [15:0] v);
    longint e;
    e = longint'(v) * (64'sd1 <<< FRAC_BITS);
    if (e > CMAX) e = CMAX;
    if (e < CMIN) e = CMIN;
    return e;
  endfunction

  function automatic longint div_floor(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  function automatic bit edge_cut(longint fixed, longint lo, longint hi, longint a,
                                  longint b, longint c, longint start,
                                  output longint along, output longint tn,
                                  output longint td);
    longint n, d;
    bit hit;
    hit = 1'b0;
    along = 0; tn = 0; td = 1;
    if (b != 0) begin
      n = -(a * fixed + c);
      if (b < 0) begin
        n = -n;
        b = -b;
      end
      if (n > lo * b && n < hi * b) begin
        along = div_floor(2 * n + b, 2 * b);
        d = fixed - start;
        tn = (d < 0) ? -d : d;
        td = b;
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic void queue_result(lvc_out_t r);
    clip_expect_q = {clip_expect_q, r};
  endfunction

  function automatic void predict_clip(input lvc_in_t p);
    longint x1, y1, x2, y2, xmin, ymin, xmax, ymax, a, b, c, al, tn, td, t;
    longint hx[4], hy[4], htn[4], htd[4];
    bit in1, in2;
    int n;
    lvc_out_t r;
    x1 = p.first_x; y1 = p.first_y; x2 = p.second_x; y2 = p.second_y;
    xmin = edge_fixed(vw_min_x); ymin = edge_fixed(vw_min_y);
    xmax = edge_fixed(vw_max_x); ymax = edge_fixed(vw_max_y);
    in1 = x1 >= xmin && x1 <= xmax && y1 >= ymin && y1 <= ymax;
    in2 = x2 >= xmin && x2 <= xmax && y2 >= ymin && y2 <= ymax;
    a = y1 - y2; b = x2 - x1; c = x1 * y2 - x2 * y1;
    n = 0;
    if (in1 && in2) begin
      r = '{clip_x: p.first_x, clip_y: p.first_y, point_valid: 1'b1, last: 1'b0};
      queue_result(r);
      r = '{clip_x: p.second_x, clip_y: p.second_y, point_valid: 1'b1, last: 1'b1};
      queue_result(r);
      return;
    end
    if (edge_cut(xmin, ymin, ymax, a, b, c, x1, al, tn, td)) begin
      hx[n] = xmin; hy[n] = al; htn[n] = tn; htd[n] = td; n++;
    end
    if (edge_cut(xmax, ymin, ymax, a, b, c, x1, al, tn, td)) begin
      hx[n] = xmax; hy[n] = al; htn[n] = tn; htd[n] = td; n++;
    end
    if (edge_cut(ymax, xmin, xmax, b, a, c, y1, al, tn, td)) begin
      hx[n] = al; hy[n] = ymax; htn[n] = tn; htd[n] = td; n++;
    end
    if (edge_cut(ymin, xmin, xmax, b, a, c, y1, al, tn, td)) begin
      hx[n] = al; hy[n] = ymin; htn[n] = tn; htd[n] = td; n++;
    end
    if (n == 0) begin
      r = '{clip_x: '0, clip_y: '0, point_valid: 1'b0, last: 1'b1};
      queue_result(r);
      return;
    end
    if (n == 1) begin
      r = '{clip_x: coord_t'(hx[0]), clip_y: coord_t'(hy[0]), point_valid: 1'b1,
            last: 1'b1};
      queue_result(r);
      return;
    end
    if (n == 2) begin
      if (htn[0] * htd[1] > htn[1] * htd[0]) begin
        t = hx[0]; hx[0] = hx[1]; hx[1] = t;
        t = hy[0]; hy[0] = hy[1]; hy[1] = t;
      end
      if (in1) begin
        hx[0] = x1; hy[0] = y1;
      end else if (in2) begin
        hx[1] = x2; hy[1] = y2;
      end
    end
    r = '{clip_x: coord_t'(hx[0]), clip_y: coord_t'(hy[0]), point_valid: 1'b1,
          last: 1'b0};
    queue_result(r);
    r = '{clip_x: coord_t'(hx[1]), clip_y: coord_t'(hy[1]), point_valid: 1'b1,
          last: 1'b1};
    queue_result(r);
  endfunction

  function automatic int gap_len();
    if (no_idle) return 0;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7, 8, 9: return 0;
      19:      return $urandom_range(20, 80);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  task automatic send_line(lvc_in_t p);
    int g;
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_clip(p);
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (clip_expect_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic set_view(int x0, int y0, int x1, int y1);
    int vals[4];
    drain();
    vals = '{x0, y0, x1, y1};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= cfg_reg_e'(i);
      cfg_wdata_i <= vals[i][15:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vw_min_x = 16'(x0); vw_min_y = 16'(y0); vw_max_x = 16'(x1); vw_max_y = 16'(y1);
  endtask

  function automatic lvc_in_t mk(longint ax, longint ay, longint bx, longint by);
    lvc_in_t p;
    p.first_x = coord_t'(ax); p.first_y = coord_t'(ay);
    p.second_x = coord_t'(bx); p.second_y = coord_t'(by);
    return p;
  endfunction

  function automatic longint rand_coord(longint lo, longint hi);
    longint span, v;
    span = (hi > lo) ? hi - lo : 1024;
    case ($urandom_range(0, 9))
      0:       v = longint'($signed(24'($urandom())));
      1:       v = $urandom_range(0, 1) ? lo : hi;
      2:       v = lo + longint'($urandom_range(0, 4)) - 2;
      3:       v = hi + longint'($urandom_range(0, 4)) - 2;
      default: v = lo - span / 2 + longint'($urandom() % (2 * span + 1));
    endcase
    if (v > CMAX) v = CMAX;
    if (v < CMIN) v = CMIN;
    return v;
  endfunction

  task automatic random_lines(int count);
    longint xl, xh, yl, yh, ax, ay;
    for (int i = 0; i < count; i++) begin
      xl = edge_fixed(vw_min_x); xh = edge_fixed(vw_max_x);
      yl = edge_fixed(vw_min_y); yh = edge_fixed(vw_max_y);
      ax = rand_coord(xl, xh);
      ay = rand_coord(yl, yh);
      case ($urandom_range(0, 9))
        0:       send_line(mk(ax, ay, ax, ay));
        1:       send_line(mk(ax, ay, rand_coord(xl, xh), ay));
        2:       send_line(mk(ax, ay, ax, rand_coord(yl, yh)));
        default: send_line(mk(ax, ay, rand_coord(xl, xh), rand_coord(yl, yh)));
      endcase
    end
  endtask

  task automatic test_basic_cases();
    no_idle = 1'b1;
    send_line(mk(100 * 256, 100 * 256, 500 * 256, 300 * 256));
    send_line(mk(0, 0, 1023 * 256, 767 * 256));
    send_line(mk(-100 * 256, 384 * 256, 2000 * 256, 384 * 256));
    send_line(mk(512 * 256, -50 * 256, 512 * 256, 900 * 256));
    send_line(mk(100 * 256, 100 * 256, 2000 * 256, 700 * 256));
    send_line(mk(-500 * 256, 100 * 256, 300 * 256, 200 * 256));
    send_line(mk(-10 * 256, -10 * 256, -10 * 256, -10 * 256));
    send_line(mk(-10 * 256, -10 * 256, -20 * 256, -30 * 256));
    send_line(mk(0, 0, 100 * 256, 200 * 256));
    send_line(mk(-256, -256, 256, 256));
    send_line(mk(0, 0, 0, 767 * 256));
    send_line(mk(-5 * 256, 0, 2000 * 256, 0));
    send_line(mk(CMAX, CMAX, CMIN, CMIN));
    send_line(mk(CMIN, CMAX, CMAX, CMIN));
    send_line(mk(CMAX, 0, CMIN, 0));
    send_line(mk(3, 5, 700 * 256 + 129, 800 * 256 - 77));
    send_line(mk(2000 * 256, 100 * 256, -300 * 256, 200 * 256));
    send_line(mk(-1, 383 * 256, 1024 * 256 + 1, 383 * 256 + 7));
    no_idle = 1'b0;
    random_lines(20);
  endtask

  task automatic test_view_extremes();
    set_view(-32768, -32768, 32767, 32767);
    send_line(mk(CMAX, CMAX, CMIN, CMIN));
    send_line(mk(0, 0, 5, 7));
    random_lines(40);
    set_view(10, 10, 10, 10);
    send_line(mk(10 * 256, 10 * 256, 10 * 256, 10 * 256));
    random_lines(30);
    set_view(100, 100, -100, -100);
    random_lines(30);
    set_view(-4, -3, 4, 3);
    random_lines(60);
  endtask

  task automatic test_random_lines();
    int x0, y0;
    set_view(0, 0, 1023, 767);
    random_lines(150);
    for (int k = 0; k < 4; k++) begin
      x0 = $signed(16'($urandom()));
      y0 = $signed(16'($urandom()));
      if ($urandom_range(0, 3) != 0)
        set_view(x0 / 4, y0 / 4, x0 / 4 + $urandom_range(1, 2000),
                 y0 / 4 + $urandom_range(1, 2000));
      else
        set_view(x0, y0, $signed(16'($urandom())), $signed(16'($urandom())));
      no_idle = (k == 1);
      random_lines(100);
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (clip_expect_q.size() == 0) begin
          $display("unexpected result transfer at %0t", $realtime);
          err_count++;
        end else begin
          if (out_data_o.clip_x !== clip_expect_q[0].clip_x)
            report_mismatch("clip_x", out_data_o.clip_x, clip_expect_q[0].clip_x);
          if (out_data_o.clip_y !== clip_expect_q[0].clip_y)
            report_mismatch("clip_y", out_data_o.clip_y, clip_expect_q[0].clip_y);
          if (out_data_o.point_valid !== clip_expect_q[0].point_valid)
            report_mismatch("point_valid", out_data_o.point_valid,
                            clip_expect_q[0].point_valid);
          if (out_data_o.last !== clip_expect_q[0].last)
            report_mismatch("last", out_data_o.last, clip_expect_q[0].last);
          void'(clip_expect_q.pop_front());
        end
      end
      if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_MAX) begin
        $display("line_viewport_clip_core_tb failed");
        $finish;
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left  <= stall_left - 1;
      end else if (!no_idle && $urandom_range(0, 9) < 3) begin
        out_ready_i <= 1'b0;
        stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_basic_cases();
    test_view_extremes();
    test_random_lines();
    drain();
    if (err_count == 0) begin
      $display("line_viewport_clip_core_tb passed");
    end else begin
      $display("line_viewport_clip_core_tb failed");
    end
    $finish;
  end

endmodule
